>>> rtl/arxh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ARX hash absorb unit.
// No dependencies; imported by the controller, datapath and top level.
package arxh_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned PosW   = 3;
    localparam int unsigned Lanes  = 8;
    localparam int unsigned RndW   = 7;
    localparam int unsigned CntW   = 3;
    localparam int unsigned SaltW  = 64;
    localparam int unsigned SCntW  = 4;
    localparam int unsigned CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] CFG_SALT_01 = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_SALT_23 = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_SALT_45 = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SALT_67 = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SALT_CNT = 3'd4;

    localparam logic [PosW-1:0] LAST_POS = 3'd7;

    localparam logic [WordW-1:0] IV_WORDS [Lanes] = '{
        32'h72000000, 32'hacdef012, 32'h0059c491, 32'hb8a79b02,
        32'h31ba94b9, 32'h45000057, 32'hb5f3810a, 32'h8a348b7d
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_RND_A,
        ST_RND_B,
        ST_FEED,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ABSORB,
        OP_HALF_A,
        OP_HALF_B,
        OP_FEED,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [PosW-1:0] pos;
        logic            zero_word;
        logic [PosW-1:0] sel;
    } dp_cmd_t;

    function automatic logic [WordW-1:0] rol32(input logic [WordW-1:0] v,
                                               input int unsigned n);
        rol32 = (v << n) | (v >> (WordW - n));
    endfunction

endpackage

>>> rtl/arxh_ctrl.sv
`timescale 1ns / 1ps
// Controller for the ARX hash absorb unit: handshakes, word position,
// round and digest counters. Depends on arxh_pkg.
module arxh_ctrl import arxh_pkg::*; #(
    parameter int unsigned ROUNDS = 80
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CntW-1:0]     byte_count,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                digest_end,
    output dp_cmd_t             cmd
);

    localparam logic [RndW-1:0] RND_LAST = RndW'(ROUNDS - 1);

    state_t            state_reg, state_next;
    logic [PosW-1:0]   pos_reg, pos_next;
    logic [RndW-1:0]   rnd_reg, rnd_next;
    logic [PosW-1:0]   emit_reg, emit_next;
    logic              fin_reg, fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            rnd_reg   <= '0;
            emit_reg  <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            rnd_reg   <= rnd_next;
            emit_reg  <= emit_next;
            fin_reg   <= fin_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        rnd_next      = rnd_reg;
        emit_next     = emit_reg;
        fin_next      = fin_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        digest_end    = (emit_reg == LAST_POS);
        cmd.op        = OP_NONE;
        cmd.pos       = pos_reg;
        cmd.zero_word = 1'b0;
        cmd.sel       = emit_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    fin_next = last;
                    if (last && pos_reg == '0 && byte_count == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.op = OP_ABSORB;
                        if (pos_reg == LAST_POS)
                        begin
                            pos_next   = '0;
                            state_next = ST_RND_A;
                        end
                        else
                        begin
                            pos_next   = pos_reg + 1'b1;
                            state_next = last ? ST_PAD : ST_IDLE;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                cmd.op        = OP_ABSORB;
                cmd.zero_word = 1'b1;
                if (pos_reg == LAST_POS)
                begin
                    pos_next   = '0;
                    state_next = ST_RND_A;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            ST_RND_A:
            begin
                cmd.op     = OP_HALF_A;
                state_next = ST_RND_B;
            end
            ST_RND_B:
            begin
                cmd.op = OP_HALF_B;
                if (rnd_reg == RND_LAST)
                begin
                    rnd_next   = '0;
                    state_next = ST_FEED;
                end
                else
                begin
                    rnd_next   = rnd_reg + 1'b1;
                    state_next = ST_RND_A;
                end
            end
            ST_FEED:
            begin
                cmd.op     = OP_FEED;
                state_next = fin_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (emit_reg == LAST_POS)
                    begin
                        cmd.op     = OP_CLEAR;
                        emit_next  = '0;
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_next = emit_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/arxh_dp.sv
`timescale 1ns / 1ps
// Datapath for the ARX hash absorb unit: chaining state, saved state,
// whitening and the half-round logic. Depends on arxh_pkg.
module arxh_dp import arxh_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    input  logic [WordW-1:0]    data_word,
    input  logic [CntW-1:0]     byte_count,
    input  logic [SaltW-1:0]    salt_01,
    input  logic [SaltW-1:0]    salt_23,
    input  logic [SaltW-1:0]    salt_45,
    input  logic [SaltW-1:0]    salt_67,
    input  logic [SCntW-1:0]    salt_count,
    output logic [WordW-1:0]    digest_word
);

    logic [WordW-1:0] chain_reg [Lanes];
    logic [WordW-1:0] chain_next [Lanes];
    logic [WordW-1:0] saved_reg [Lanes];
    logic [WordW-1:0] a [Lanes];
    logic [WordW-1:0] b [Lanes];
    logic [WordW-1:0] mask;
    logic [WordW-1:0] word_in;
    logic [SaltW-1:0] salt_pair;
    logic [WordW-1:0] salt_word;
    logic [WordW-1:0] white;

    // mask off missing bytes, counts above four act as four
    always_comb
    begin
        unique case (byte_count)
            3'd0:    mask = 32'h00000000;
            3'd1:    mask = 32'hff000000;
            3'd2:    mask = 32'hffff0000;
            3'd3:    mask = 32'hffffff00;
            default: mask = 32'hffffffff;
        endcase
        word_in = cmd.zero_word ? '0 : (data_word & mask);
    end

    always_comb
    begin
        unique case (cmd.pos[PosW-1:1])
            2'd0:    salt_pair = salt_01;
            2'd1:    salt_pair = salt_23;
            2'd2:    salt_pair = salt_45;
            default: salt_pair = salt_67;
        endcase
        salt_word = cmd.pos[0] ? salt_pair[WordW-1:0] : salt_pair[SaltW-1:WordW];
        if ({1'b0, cmd.pos} < salt_count)
        begin
            white = (IV_WORDS[cmd.pos] ^ salt_word) + 32'd1;
        end
        else
        begin
            white = IV_WORDS[cmd.pos];
        end
    end

    // first half of a round
    always_comb
    begin
        a[0] = chain_reg[0] + chain_reg[4];
        a[1] = rol32(chain_reg[1] ^ chain_reg[5], 2);
        a[2] = chain_reg[2] + chain_reg[6];
        a[3] = rol32(chain_reg[3] ^ chain_reg[7], 5);
        a[4] = chain_reg[4] + a[2];
        a[5] = rol32(chain_reg[5] ^ a[3], 7);
        a[6] = chain_reg[6] + a[5];
        a[7] = rol32(chain_reg[7] ^ a[6], 12);
    end

    // second half of a round, before the word rotation
    always_comb
    begin
        b[0] = chain_reg[0] ^ chain_reg[2] ^ chain_reg[4] ^ chain_reg[6];
        b[1] = (chain_reg[1] + chain_reg[3]) + (chain_reg[5] + chain_reg[7]);
        b[2] = rol32(chain_reg[2] ^ b[0], 3);
        b[3] = rol32(chain_reg[3] ^ b[1], 8);
        b[4] = chain_reg[4] ^ b[2];
        b[5] = chain_reg[5] ^ b[3];
        b[6] = chain_reg[6] + b[4];
        b[7] = chain_reg[7] + b[5];
    end

    always_comb
    begin
        for (int i = 0; i < Lanes; i++)
        begin
            chain_next[i] = chain_reg[i];
        end
        unique case (cmd.op)
            OP_ABSORB:
            begin
                chain_next[cmd.pos] = chain_reg[cmd.pos] ^ word_in ^ white;
            end
            OP_HALF_A:
            begin
                for (int i = 0; i < Lanes; i++)
                begin
                    chain_next[i] = a[i];
                end
            end
            OP_HALF_B:
            begin
                for (int i = 0; i < Lanes - 1; i++)
                begin
                    chain_next[i] = b[i + 1];
                end
                chain_next[Lanes - 1] = b[0];
            end
            OP_FEED:
            begin
                for (int i = 0; i < Lanes; i++)
                begin
                    chain_next[i] = chain_reg[i] + saved_reg[i];
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < Lanes; i++)
                begin
                    chain_next[i] = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Lanes; i++)
            begin
                chain_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < Lanes; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    // snapshot the block state as its last word goes in
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_ABSORB && cmd.pos == LAST_POS)
        begin
            for (int i = 0; i < Lanes; i++)
            begin
                saved_reg[i] <= chain_next[i];
            end
        end
    end

    assign digest_word = chain_reg[cmd.sel];

endmodule

>>> rtl/arx_hash_block_absorb_unit.sv
`timescale 1ns / 1ps
// Top level of the ARX hash absorb unit: configuration registers and the
// controller/datapath pair. Depends on arxh_pkg, arxh_ctrl and arxh_dp.
//
//  channel   handshake             payload
//  input     in_valid / in_ready   data_word, byte_count, last
//  output    out_valid / out_ready digest_word, digest_end
//  config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// Words inside a block are taken back to back; the eighth word of a block starts
// the rounds, two half-round states each in the shared round unit, and feed-forward,
// with no word taken meanwhile. A last word inside a block also adds zero padding up to
// the block end, the rounds, feed-forward and then the eight digest words.
// Reset clears the chain, counters and configuration; the saved copy is not reset.
// The digest stalls in place while out_ready is low.
module arx_hash_block_absorb_unit import arxh_pkg::*; #(
    parameter int unsigned ROUNDS = 80
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [WordW-1:0]    data_word,
    input  logic [CntW-1:0]     byte_count,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [WordW-1:0]    digest_word,
    output logic                digest_end,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [SaltW-1:0]    cfg_data
);

    logic [SaltW-1:0] salt_01_reg;
    logic [SaltW-1:0] salt_23_reg;
    logic [SaltW-1:0] salt_45_reg;
    logic [SaltW-1:0] salt_67_reg;
    logic [SCntW-1:0] salt_cnt_reg;
    dp_cmd_t          cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            salt_01_reg  <= '0;
            salt_23_reg  <= '0;
            salt_45_reg  <= '0;
            salt_67_reg  <= '0;
            salt_cnt_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SALT_01:  salt_01_reg  <= cfg_data;
                CFG_SALT_23:  salt_23_reg  <= cfg_data;
                CFG_SALT_45:  salt_45_reg  <= cfg_data;
                CFG_SALT_67:  salt_67_reg  <= cfg_data;
                CFG_SALT_CNT: salt_cnt_reg <= cfg_data[SCntW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    arxh_ctrl #(
        .ROUNDS (ROUNDS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_count (byte_count),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digest_end (digest_end),
        .cmd        (cmd)
    );

    arxh_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_word   (data_word),
        .byte_count  (byte_count),
        .salt_01     (salt_01_reg),
        .salt_23     (salt_23_reg),
        .salt_45     (salt_45_reg),
        .salt_67     (salt_67_reg),
        .salt_count  (salt_cnt_reg),
        .digest_word (digest_word)
    );

endmodule
